/* hw/rtl/cpsg_pkg.sv */
// Package for the closed path setpoint generator: types, constants and helper functions.
`timescale 1ns / 1ps

package cpsg_pkg;

    // Default depth of the sine table.
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    // Field and register widths.
    localparam int CFG_W   = 31;
    localparam int COORD_W = 32;
    localparam int WIDE_W  = 40;
    localparam int SINE_W  = 18;

    // Reset values of the configuration registers and of the position.
    localparam logic [CFG_W-1:0]          LEG_LENGTH_RESET    = 31'd65536;
    localparam logic [CFG_W-1:0]          ARC_WIDTH_RESET     = 31'd65536;
    localparam logic [CFG_W-1:0]          ARC_RECIP_RESET     = 31'd65536;
    localparam logic [CFG_W-1:0]          SAMPLE_PERIOD_RESET = 31'd655;
    localparam logic signed [COORD_W-1:0] START_X_RESET       = 32'sd0;
    localparam logic signed [COORD_W-1:0] START_Y_RESET       = 32'sd0;

    // Region tolerance of 0.1 m in Q16.16, widened for the region compares.
    localparam logic signed [WIDE_W-1:0] DELTA_WIDE = 40'sd6554;
    localparam logic signed [WIDE_W-1:0] WIDE_ZERO  = 40'sd0;

    // Pi in Q2.30, used to build the sine table.
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Step divisor 1000 applied after the 16 bit fraction shift.
    localparam logic [10:0] STEP_DIVISOR = 11'd1000;

    // Iteration limits of the serial units.
    localparam logic [5:0] MUL_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST = 6'd45;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_LEG_LENGTH    = 3'd0,
        CFG_ARC_WIDTH     = 3'd1,
        CFG_ARC_RECIP     = 3'd2,
        CFG_SAMPLE_PERIOD = 3'd3,
        CFG_START_X       = 3'd4,
        CFG_START_Y       = 3'd5
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_STEP,
        S_DIV,
        S_REGION,
        S_MUL_RECIP,
        S_INDEX,
        S_ROM,
        S_ARC_LOAD,
        S_MUL_ARC,
        S_FINAL
    } state_t;

    // Saturate a wide signed sum to the signed 32 bit range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/closed_path_setpoint_generator_unit.sv */
// Top level of the closed path setpoint generator: sequencer, serial arithmetic and sine table.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_        in         tdata[31:0] speed (Q16.16 mm/s)
// m_        out        tdata[31:0] ref_x, tdata[63:32] ref_y, tuser[0] off_path
// cfg_      in         write enable, register index, 32 bit write data
//
// The result of a beat enters the output register once the sequence below has run, and the
// input is ready again on the next cycle, so a new beat is accepted only after the previous
// one is loaded there. The sequence is made up of the shared shift-add multiplier, which runs
// three passes, the restoring divide by 1000, and five steps for the region test, the
// table index, the table read, the arc load and the output load.
// Reset is synchronous and active low; it restores the register defaults and the start point.
// A result that waits on m_tready blocks only the final step, so one more item may be
// accepted and worked on while the previous beat is still held at the output.

module closed_path_setpoint_generator_unit
    import cpsg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] speed

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] ref_x, [63:32] ref_y
    output logic        m_tuser,    // [0] off_path

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    // Table index width and the width of the constant product that scales the fraction.
    localparam int K_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int KP_W = 17 + $clog2(SINE_TABLE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Sine table, built at elaboration from a Q2.30 Taylor series on the
    // reduced quarter angle and rounded to signed Q2.16.
    // ------------------------------------------------------------------
    logic signed [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

    genvar g;
    for (g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
        localparam longint unsigned DEP   = SINE_TABLE_DEPTH;
        localparam longint unsigned W0    = 4 * g;
        localparam bit              NEG   = (W0 >= 2 * DEP);
        localparam longint unsigned W1    = NEG ? (W0 - 2 * DEP) : W0;
        localparam longint unsigned W2    = (W1 > DEP) ? (2 * DEP - W1) : W1;
        localparam longint unsigned THETA = (PI_Q30 * W2) / (2 * DEP);
        localparam longint unsigned T2    = (THETA * THETA) >> 30;
        localparam longint unsigned TERM1 = ((THETA * T2) >> 30) / 6;
        localparam longint unsigned TERM2 = ((TERM1 * T2) >> 30) / 20;
        localparam longint unsigned TERM3 = ((TERM2 * T2) >> 30) / 42;
        localparam longint unsigned TERM4 = ((TERM3 * T2) >> 30) / 72;
        localparam longint unsigned TERM5 = ((TERM4 * T2) >> 30) / 110;
        localparam longint unsigned TERM6 = ((TERM5 * T2) >> 30) / 156;
        localparam longint unsigned TERM7 = ((TERM6 * T2) >> 30) / 210;
        localparam longint SUM  = longint'(THETA) - longint'(TERM1) + longint'(TERM2)
                                - longint'(TERM3) + longint'(TERM4) - longint'(TERM5)
                                + longint'(TERM6) - longint'(TERM7);
        localparam longint SUM0 = (SUM < 0) ? 0 : SUM;
        localparam longint RND  = (SUM0 + 8192) / 16384;
        localparam longint CLP  = (RND > 65536) ? 65536 : RND;
        localparam longint VAL  = NEG ? -CLP : CLP;
        assign sine_rom[g] = SINE_W'(VAL);
    end

    // ------------------------------------------------------------------
    // Configuration and position registers.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]          leg_length_reg;
    logic [CFG_W-1:0]          arc_width_reg;
    logic [CFG_W-1:0]          arc_recip_reg;
    logic [CFG_W-1:0]          sample_period_reg;
    logic signed [COORD_W-1:0] pos_x_reg;
    logic signed [COORD_W-1:0] pos_y_reg;

    // Sequencer.
    state_t     state_reg;
    state_t     state_next;
    logic [5:0] cnt_reg;
    logic       cnt_last;
    logic       out_load;

    // Shared shift-add multiplier: the multiplier sits in the low word and leaves one bit
    // a cycle while the partial sum grows into the high word.
    logic [31:0] mc_reg;
    logic [31:0] mul_hi_reg;
    logic [31:0] mul_lo_reg;
    logic [32:0] mul_sum;
    logic [63:0] mul_next;
    logic [63:0] mul_prod;

    // Restoring divider by 1000, one quotient bit a cycle.
    logic [45:0] div_q_reg;
    logic [9:0]  div_rem_reg;
    logic [10:0] div_shift;
    logic        div_bit;

    // Per-item working registers.
    logic                      speed_neg_reg;
    logic signed [COORD_W-1:0] xs_reg;
    logic signed [WIDE_W-1:0]  ny_base_reg;
    logic                      rb_reg;
    logic                      re_reg;
    logic                      none_reg;
    logic [K_W-1:0]            k_reg;
    logic signed [SINE_W-1:0]  sine_reg;
    logic                      arc_neg_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tuser_reg;

    // ------------------------------------------------------------------
    // Combinational datapath.
    // ------------------------------------------------------------------
    logic [31:0]               speed_mag;
    logic signed [WIDE_W-1:0]  x_w;
    logic signed [WIDE_W-1:0]  y_w;
    logic signed [WIDE_W-1:0]  l_w;
    logic signed [WIDE_W-1:0]  w_w;
    logic signed [WIDE_W-1:0]  step_mag_w;
    logic signed [WIDE_W-1:0]  step_w;
    logic                      ra;
    logic                      rb;
    logic                      rc;
    logic                      re;
    logic                      none;
    logic signed [WIDE_W-1:0]  nx;
    logic signed [WIDE_W-1:0]  ny_base;
    logic signed [COORD_W-1:0] xs_sat;
    logic [16:0]               frac17;
    logic [KP_W-1:0]           k_prod;
    logic [16:0]               sine_mag;
    logic signed [WIDE_W-1:0]  arc_mag_w;
    logic signed [WIDE_W-1:0]  arc_w;
    logic signed [WIDE_W-1:0]  ny;
    logic signed [COORD_W-1:0] ys_sat;

    assign speed_mag = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;

    assign mul_sum  = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mc_reg} : 33'd0);
    assign mul_next = {mul_sum, mul_lo_reg[31:1]};
    assign mul_prod = {mul_hi_reg, mul_lo_reg};

    assign div_shift = {div_rem_reg, div_q_reg[45]};
    assign div_bit   = (div_shift >= STEP_DIVISOR);

    // Region tests run on the old point with everything widened to 40 bits.
    assign x_w        = {{(WIDE_W-COORD_W){pos_x_reg[COORD_W-1]}}, pos_x_reg};
    assign y_w        = {{(WIDE_W-COORD_W){pos_y_reg[COORD_W-1]}}, pos_y_reg};
    assign l_w        = $signed({{(WIDE_W-CFG_W){1'b0}}, leg_length_reg});
    assign w_w        = $signed({{(WIDE_W-CFG_W){1'b0}}, arc_width_reg});
    assign step_mag_w = $signed({3'b000, div_q_reg[36:0]});
    assign step_w     = speed_neg_reg ? (WIDE_ZERO - step_mag_w) : step_mag_w;

    assign ra   = (x_w < DELTA_WIDE) && (y_w < l_w) && (y_w >= WIDE_ZERO);
    assign rb   = (x_w < w_w + DELTA_WIDE) && (x_w > WIDE_ZERO - DELTA_WIDE) && (y_w >= l_w);
    assign rc   = (x_w >= w_w - DELTA_WIDE) && (y_w >= WIDE_ZERO) && (y_w < l_w);
    assign re   = (x_w > WIDE_ZERO - DELTA_WIDE) && (x_w < w_w + DELTA_WIDE)
               && (y_w <= WIDE_ZERO);
    assign none = !ra && !rb && !rc && !re;

    // Overlapping regions add their contributions.
    assign nx = (rb ? (x_w + step_w) : WIDE_ZERO)
              + (rc ? w_w : WIDE_ZERO)
              + (re ? (x_w - step_w) : WIDE_ZERO)
              + (none ? x_w : WIDE_ZERO);
    assign ny_base = (ra ? (y_w + step_w) : WIDE_ZERO)
                   + (rb ? l_w : WIDE_ZERO)
                   + (rc ? (y_w - step_w) : WIDE_ZERO)
                   + (none ? y_w : WIDE_ZERO);
    assign xs_sat = sat32(nx);

    // The multiplier sees x as unsigned; for a negative x the signed product differs by
    // recip times 2^32, which only flips bit 32 when recip is odd.
    assign frac17 = {mul_prod[32] ^ (xs_reg[COORD_W-1] & arc_recip_reg[0]), mul_prod[31:16]};
    assign k_prod = KP_W'(frac17) * KP_W'(SINE_TABLE_DEPTH);

    assign sine_mag = sine_reg[SINE_W-1] ? 17'(-sine_reg) : sine_reg[16:0];

    // The arc height is truncated toward zero, so the sign goes on after the shift.
    assign arc_mag_w = $signed({10'd0, mul_prod[46:17]});
    assign arc_w     = arc_neg_reg ? (WIDE_ZERO - arc_mag_w) : arc_mag_w;
    assign ny        = ny_base_reg + (rb_reg ? arc_w : WIDE_ZERO) - (re_reg ? arc_w : WIDE_ZERO);
    assign ys_sat    = sat32(ny);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_MUL_STEP;
                end
            end
            S_MUL_STEP: begin
                if (cnt_last) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (cnt_last) begin
                    state_next = S_REGION;
                end
            end
            S_REGION: begin
                state_next = S_MUL_RECIP;
            end
            S_MUL_RECIP: begin
                if (cnt_last) begin
                    state_next = S_INDEX;
                end
            end
            S_INDEX: begin
                state_next = S_ROM;
            end
            S_ROM: begin
                state_next = S_ARC_LOAD;
            end
            S_ARC_LOAD: begin
                state_next = S_MUL_ARC;
            end
            S_MUL_ARC: begin
                if (cnt_last) begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_tready = 1'b0;
        cnt_last = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_MUL_STEP, S_MUL_RECIP, S_MUL_ARC: begin
                cnt_last = (cnt_reg == MUL_LAST);
            end
            S_DIV: begin
                cnt_last = (cnt_reg == DIV_LAST);
            end
            S_FINAL: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Iteration counter for the serial units; it wraps to zero on each unit's last cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (cnt_last) begin
            cnt_reg <= 6'd0;
        end else if ((state_reg == S_MUL_STEP) || (state_reg == S_DIV)
                  || (state_reg == S_MUL_RECIP) || (state_reg == S_MUL_ARC)) begin
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mc_reg        <= speed_mag;
                    mul_hi_reg    <= 32'd0;
                    mul_lo_reg    <= {1'b0, sample_period_reg};
                    speed_neg_reg <= s_tdata[31];
                end
            end
            S_MUL_STEP: begin
                {mul_hi_reg, mul_lo_reg} <= mul_next;
                if (cnt_last) begin
                    // Drop the 16 fraction bits, then divide the rest by 1000.
                    div_q_reg   <= mul_next[61:16];
                    div_rem_reg <= 10'd0;
                end
            end
            S_DIV: begin
                div_q_reg   <= {div_q_reg[44:0], div_bit};
                div_rem_reg <= div_bit ? 10'(div_shift - STEP_DIVISOR) : div_shift[9:0];
            end
            S_REGION: begin
                xs_reg      <= xs_sat;
                ny_base_reg <= ny_base;
                rb_reg      <= rb;
                re_reg      <= re;
                none_reg    <= none;
                mc_reg      <= xs_sat;
                mul_hi_reg  <= 32'd0;
                mul_lo_reg  <= {1'b0, arc_recip_reg};
            end
            S_MUL_RECIP, S_MUL_ARC: begin
                {mul_hi_reg, mul_lo_reg} <= mul_next;
            end
            S_INDEX: begin
                k_reg <= k_prod[17 +: K_W];
            end
            S_ROM: begin
                sine_reg <= sine_rom[k_reg];
            end
            S_ARC_LOAD: begin
                mc_reg      <= {1'b0, arc_width_reg};
                mul_hi_reg  <= 32'd0;
                mul_lo_reg  <= {15'd0, sine_mag};
                arc_neg_reg <= sine_reg[SINE_W-1];
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration writes and position update. Writes to the start
    // registers load the position directly.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leg_length_reg    <= LEG_LENGTH_RESET;
            arc_width_reg     <= ARC_WIDTH_RESET;
            arc_recip_reg     <= ARC_RECIP_RESET;
            sample_period_reg <= SAMPLE_PERIOD_RESET;
            pos_x_reg         <= START_X_RESET;
            pos_y_reg         <= START_Y_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LEG_LENGTH:    leg_length_reg    <= cfg_wr_data[CFG_W-1:0];
                CFG_ARC_WIDTH:     arc_width_reg     <= cfg_wr_data[CFG_W-1:0];
                CFG_ARC_RECIP:     arc_recip_reg     <= cfg_wr_data[CFG_W-1:0];
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_wr_data[CFG_W-1:0];
                CFG_START_X:       pos_x_reg         <= $signed(cfg_wr_data);
                CFG_START_Y:       pos_y_reg         <= $signed(cfg_wr_data);
                default: begin
                end
            endcase
        end else if (out_load) begin
            pos_x_reg <= xs_reg;
            pos_y_reg <= ys_sat;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a finished beat until m_tready takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {ys_sat, xs_reg};
            m_tuser_reg <= none_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
